### rtl/core/cpap_pkg.sv
// Package for the configuration payload attribute parser.
// Holds the status codes, the record type and the sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package cpap_pkg;

    localparam int CAP_W            = 7;
    localparam int MAX_ATTRIBUTES_D = 64;
    localparam int CAP_RESET        = 64;
    localparam int Q_DEPTH          = 4;
    localparam int Q_PTR_W          = $clog2(Q_DEPTH);
    localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);
    localparam int TDATA_W          = 72;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TRUNCATED    = 3'd1,
        ST_BAD_VALUE    = 3'd2,
        ST_BAD_RESERVED = 3'd3,
        ST_BAD_LENGTH   = 3'd4,
        ST_CAPACITY     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_TYPE_HI = 2'd0,
        PH_TYPE_LO = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_LEN_LO  = 2'd3
    } phase_t;

    typedef struct packed {
        logic             final_mark;
        logic [CAP_W-1:0] attr_count;
        logic [7:0]       cfg_type;
        status_t          status;
        logic [15:0]      value_length;
        logic [15:0]      value_offset;
        logic [14:0]      attr_type;
        logic             kind;
    } rec_t;

endpackage

### rtl/core/config_payload_attribute_parser.sv
// Configuration payload attribute parser, top level.
// Depends on cpap_pkg.
//
//  channel | dir | handshake            | contents
//  s_*     | in  | s_tvalid / s_tready  | one body byte per word, s_tlast on the final byte
//  m_*     | out | m_tvalid / m_tready  | attribute or status record, m_tlast on status
//  cfg_*   | in  | cfg_we               | attr_capacity
//
// One byte per cycle while s_tready is high: the header/attribute state updates in
// the cycle a word is taken, and its records (at most two) enter a four-entry output
// queue; they show on m_tvalid from the next cycle on.
// s_tready is high while the queue has room for two records, so a stalled
// output stops input only once three records are waiting. Reset clears all body
// state and sets attr_capacity to 64; no clearing pass is needed.
`timescale 1ns / 1ps

module config_payload_attribute_parser #(
    parameter int MAX_ATTRIBUTES = cpap_pkg::MAX_ATTRIBUTES_D
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [14:0] attr_type, [30:15] value_offset, [46:31] value_length,
    // [49:47] status, [57:50] cfg_type, [64:58] attr_count, rest zero
    output logic [cpap_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser,   // [0] kind
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [cpap_pkg::CAP_W-1:0]    cfg_wdata  // attr_capacity
);
    import cpap_pkg::*;

    logic [CAP_W-1:0] capacity_reg;

    logic [15:0]      byte_offset_reg,    byte_offset_next;
    phase_t           header_phase_reg,   header_phase_next;
    logic             in_value_reg,       in_value_next;
    logic [15:0]      latched_type_reg,   latched_type_next;
    logic [15:0]      latched_length_reg, latched_length_next;
    logic [15:0]      value_left_reg,     value_left_next;
    logic [CAP_W-1:0] accepted_count_reg, accepted_count_next;
    logic [7:0]       type_byte_reg,      type_byte_next;
    status_t          error_code_reg,     error_code_next;
    logic             hdr_done_reg,       hdr_done_next;
    logic             hdr_ok_reg,         hdr_ok_next;
    logic             hdr_rsv_bad_reg,    hdr_rsv_bad_next;

    rec_t             q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    logic             s_fire, m_fire;
    logic             attr_v, stat_v;
    rec_t             attr_rec, stat_rec, rec_0, rec_1;
    logic [CAP_W-1:0] cap;
    logic [15:0]      len_full, vl_dec;
    logic             finish;
    logic [7:0]       b;
    status_t          st;
    rec_t             head;

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign b        = s_tdata;
    assign s_tready = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);

    always_comb
    begin
        if (int'(capacity_reg) > MAX_ATTRIBUTES)
            cap = CAP_W'(MAX_ATTRIBUTES);
        else
            cap = capacity_reg;
    end

    always_comb
    begin
        byte_offset_next    = byte_offset_reg;
        header_phase_next   = header_phase_reg;
        in_value_next       = in_value_reg;
        latched_type_next   = latched_type_reg;
        latched_length_next = latched_length_reg;
        value_left_next     = value_left_reg;
        accepted_count_next = accepted_count_reg;
        type_byte_next      = type_byte_reg;
        error_code_next     = error_code_reg;
        hdr_done_next       = hdr_done_reg;
        hdr_ok_next         = hdr_ok_reg;
        hdr_rsv_bad_next    = hdr_rsv_bad_reg;
        len_full            = {latched_length_reg[15:8], b};
        vl_dec              = value_left_reg - 16'd1;
        finish              = 1'b0;
        attr_v              = 1'b0;
        attr_rec            = '0;

        if (error_code_reg == ST_OK)
        begin
            byte_offset_next = byte_offset_reg + 16'd1;
            if (!hdr_done_reg)
            begin
                if (byte_offset_reg == 16'd0)
                    type_byte_next = b;
                else if (b != 8'd0)
                    hdr_rsv_bad_next = 1'b1;
                if (byte_offset_reg == 16'd3)
                begin
                    hdr_done_next = 1'b1;
                    if (type_byte_reg < 8'd1 || type_byte_reg > 8'd4)
                        error_code_next = ST_BAD_VALUE;
                    else if (hdr_rsv_bad_next)
                        error_code_next = ST_BAD_RESERVED;
                    else
                        hdr_ok_next = 1'b1;
                end
            end
            else if (!in_value_reg)
            begin
                unique case (header_phase_reg)
                    PH_TYPE_HI:
                    begin
                        latched_type_next = {b, 8'd0};
                        header_phase_next = PH_TYPE_LO;
                    end
                    PH_TYPE_LO:
                    begin
                        latched_type_next = {latched_type_reg[15:8], b};
                        header_phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        latched_length_next = {b, 8'd0};
                        header_phase_next   = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        latched_length_next = len_full;
                        header_phase_next   = PH_TYPE_HI;
                        if (accepted_count_reg >= cap)
                            error_code_next = ST_CAPACITY;
                        else if (len_full == 16'd0)
                            finish = 1'b1;
                        else
                        begin
                            in_value_next   = 1'b1;
                            value_left_next = len_full;
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                value_left_next = vl_dec;
                if (vl_dec == 16'd0)
                begin
                    in_value_next = 1'b0;
                    finish        = 1'b1;
                end
            end
        end

        // Value complete: reject a set reserved type bit, else emit the record
        if (finish)
        begin
            if (latched_type_next[15])
                error_code_next = ST_BAD_RESERVED;
            else
            begin
                accepted_count_next   = accepted_count_reg + CAP_W'(1);
                attr_v                = 1'b1;
                attr_rec.kind         = 1'b0;
                attr_rec.attr_type    = latched_type_next[14:0];
                attr_rec.value_offset = byte_offset_reg + 16'd1 - latched_length_next;
                attr_rec.value_length = latched_length_next;
                attr_rec.status       = ST_OK;
                attr_rec.cfg_type     = hdr_ok_next ? type_byte_next : 8'd0;
                attr_rec.attr_count   = accepted_count_next;
                attr_rec.final_mark   = 1'b0;
            end
        end

        st = error_code_next;
        if (st == ST_OK)
        begin
            if (!hdr_done_next)
                st = ST_TRUNCATED;
            else if (in_value_next || header_phase_next != PH_TYPE_HI)
                st = ST_BAD_LENGTH;
        end
        stat_v                = s_tlast;
        stat_rec              = '0;
        stat_rec.kind         = 1'b1;
        stat_rec.status       = st;
        stat_rec.cfg_type     = hdr_ok_next ? type_byte_next : 8'd0;
        stat_rec.attr_count   = accepted_count_next;
        stat_rec.final_mark   = 1'b1;

        // End of body: drop all body state
        if (s_tlast)
        begin
            byte_offset_next    = '0;
            header_phase_next   = PH_TYPE_HI;
            in_value_next       = 1'b0;
            latched_type_next   = '0;
            latched_length_next = '0;
            value_left_next     = '0;
            accepted_count_next = '0;
            type_byte_next      = '0;
            error_code_next     = ST_OK;
            hdr_done_next       = 1'b0;
            hdr_ok_next         = 1'b0;
            hdr_rsv_bad_next    = 1'b0;
        end

        rec_0 = attr_v ? attr_rec : stat_rec;
        rec_1 = stat_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg       <= CAP_W'(CAP_RESET);
            byte_offset_reg    <= '0;
            header_phase_reg   <= PH_TYPE_HI;
            in_value_reg       <= 1'b0;
            latched_type_reg   <= '0;
            latched_length_reg <= '0;
            value_left_reg     <= '0;
            accepted_count_reg <= '0;
            type_byte_reg      <= '0;
            error_code_reg     <= ST_OK;
            hdr_done_reg       <= 1'b0;
            hdr_ok_reg         <= 1'b0;
            hdr_rsv_bad_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (s_fire)
            begin
                byte_offset_reg    <= byte_offset_next;
                header_phase_reg   <= header_phase_next;
                in_value_reg       <= in_value_next;
                latched_type_reg   <= latched_type_next;
                latched_length_reg <= latched_length_next;
                value_left_reg     <= value_left_next;
                accepted_count_reg <= accepted_count_next;
                type_byte_reg      <= type_byte_next;
                error_code_reg     <= error_code_next;
                hdr_done_reg       <= hdr_done_next;
                hdr_ok_reg         <= hdr_ok_next;
                hdr_rsv_bad_reg    <= hdr_rsv_bad_next;
            end
        end
    end

    // Output queue: up to two records in, one out per cycle while m_tready is high
    logic [1:0] n_push;
    assign n_push = s_fire ? ({1'b0, attr_v} + {1'b0, stat_v}) : 2'd0;

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_reg[wr_ptr_reg] <= rec_0;
        if (n_push == 2'd2)
            q_reg[wr_ptr_reg + Q_PTR_W'(1)] <= rec_1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(n_push);
            if (m_fire)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_reg + Q_CNT_W'(n_push) - Q_CNT_W'(m_fire);
        end
    end

    assign head    = q_reg[rd_ptr_reg];
    assign m_tuser = head.kind;
    assign m_tlast = head.final_mark;
    assign m_tdata = {7'd0, head.attr_count, head.cfg_type, head.status,
                      head.value_length, head.value_offset, head.attr_type};

endmodule

### tb/testbench.sv
// Self-checking bench for config_payload_attribute_parser: body bytes in, records out.
// Depends on cpap_pkg and the parser RTL; predicts every record in-line and
// compares on the output stream, with random stalls on both sides.
`timescale 1ns / 1ps

module testbench;
    import cpap_pkg::*;

    localparam logic REC_ATTR   = 1'b0;
    localparam logic REC_STATUS = 1'b1;
    localparam int   STALL_LIMIT   = 5000;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   PHASE_BYTES   = 80;
    localparam int   N_PHASES      = 8;
    localparam logic [6:0] CAP_PLAN [N_PHASES] =
        '{7'd0, 7'd1, 7'd127, 7'd2, 7'd65, 7'd64, 7'd3, 7'd0};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } body_word_t;

    typedef struct packed {
        logic        kind;
        logic [14:0] attr_type;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        status_t     status;
        logic [7:0]  cfg_type;
        logic [6:0]  attr_count;
        logic        final_mark;
    } record_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CAP_W-1:0]      cfg_wdata = 7'd0;

    body_word_t  body_words[$];
    body_word_t  next_word;
    logic [7:0]  body_bytes[$];
    record_t     expected_records[$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    logic [31:0] cyc = '0;
    logic        quiet;

    // Parser state as the bench sees it
    logic [6:0]  attr_limit = 7'd64;
    logic [15:0] body_pos = '0;
    phase_t      attr_phase = PH_TYPE_HI;
    logic        in_value = 1'b0;
    logic [15:0] attr_word = '0;
    logic [15:0] attr_len = '0;
    logic [15:0] value_left = '0;
    logic [6:0]  accepted = '0;
    logic [7:0]  cfg_byte = '0;
    status_t     body_err = ST_OK;
    logic        hdr_done = 1'b0;
    logic        hdr_ok = 1'b0;
    logic        rsv_bad = 1'b0;

    config_payload_attribute_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // No idling while cycle counter bits [11:10] are both set, a quarter of the time
    assign quiet = (cyc[11:10] == 2'b11);

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    function automatic void close_attr(input logic [15:0] pos);
        record_t r;
        if (attr_word[15])
            body_err = ST_BAD_RESERVED;
        else
        begin
            accepted = accepted + 7'd1;
            r = '0;
            r.kind         = REC_ATTR;
            r.attr_type    = attr_word[14:0];
            r.value_offset = pos + 16'd1 - attr_len;
            r.value_length = attr_len;
            r.status       = ST_OK;
            r.cfg_type     = hdr_ok ? cfg_byte : 8'h00;
            r.attr_count   = accepted;
            r.final_mark   = 1'b0;
            expected_records.push_back(r);
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [15:0] pos;
        logic [6:0]  eff_cap;
        status_t     st;
        record_t     r;
        pos = body_pos;
        if (body_err == ST_OK)
        begin
            if (!hdr_done)
            begin
                if (pos == 16'd0)
                    cfg_byte = b;
                else if (b != 8'h00)
                    rsv_bad = 1'b1;
                if (pos == 16'd3)
                begin
                    hdr_done = 1'b1;
                    if (cfg_byte < 8'd1 || cfg_byte > 8'd4)
                        body_err = ST_BAD_VALUE;
                    else if (rsv_bad)
                        body_err = ST_BAD_RESERVED;
                    else
                        hdr_ok = 1'b1;
                end
            end
            else if (!in_value)
            begin
                case (attr_phase)
                    PH_TYPE_HI:
                    begin
                        attr_word = {b, 8'h00};
                        attr_phase = PH_TYPE_LO;
                    end
                    PH_TYPE_LO:
                    begin
                        attr_word[7:0] = b;
                        attr_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        attr_len = {b, 8'h00};
                        attr_phase = PH_LEN_LO;
                    end
                    default:
                    begin
                        attr_len[7:0] = b;
                        attr_phase = PH_TYPE_HI;
                        eff_cap = (attr_limit > 7'(MAX_ATTRIBUTES_D)) ?
                                  7'(MAX_ATTRIBUTES_D) : attr_limit;
                        // capacity wins over everything else at the length byte
                        if (accepted >= eff_cap)
                            body_err = ST_CAPACITY;
                        else if (attr_len == 16'h0000)
                            close_attr(pos);
                        else
                        begin
                            in_value = 1'b1;
                            value_left = attr_len;
                        end
                    end
                endcase
            end
            else
            begin
                value_left = value_left - 16'd1;
                if (value_left == 16'h0000)
                begin
                    in_value = 1'b0;
                    close_attr(pos);
                end
            end
            body_pos = pos + 16'd1;
        end
        if (last)
        begin
            st = body_err;
            if (st == ST_OK)
            begin
                if (!hdr_done)
                    st = ST_TRUNCATED;
                else if (in_value || attr_phase != PH_TYPE_HI)
                    st = ST_BAD_LENGTH;
            end
            r = '0;
            r.kind       = REC_STATUS;
            r.status     = st;
            r.cfg_type   = hdr_ok ? cfg_byte : 8'h00;
            r.attr_count = accepted;
            r.final_mark = 1'b1;
            expected_records.push_back(r);
            // start the next body from scratch; the capacity stays
            body_pos = '0;
            attr_phase = PH_TYPE_HI;
            in_value = 1'b0;
            attr_word = '0;
            attr_len = '0;
            value_left = '0;
            accepted = '0;
            cfg_byte = '0;
            body_err = ST_OK;
            hdr_done = 1'b0;
            hdr_ok = 1'b0;
            rsv_bad = 1'b0;
        end
    endfunction

    task automatic take_record();
        record_t got;
        record_t want;
        got.kind         = m_tuser;
        got.attr_type    = m_tdata[14:0];
        got.value_offset = m_tdata[30:15];
        got.value_length = m_tdata[46:31];
        got.status       = status_t'(m_tdata[49:47]);
        got.cfg_type     = m_tdata[57:50];
        got.attr_count   = m_tdata[64:58];
        got.final_mark   = m_tlast;
        if (m_tdata[TDATA_W-1:65] != '0)
            flag_mismatch("pad bits", 32'(m_tdata[TDATA_W-1:65]), 32'd0);
        if (expected_records.size() == 0)
            flag_mismatch("record with none expected, kind", 32'(got.kind), 32'd0);
        else
        begin
            want = expected_records.pop_front();
            if (got.kind != want.kind)
                flag_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.attr_type != want.attr_type)
                flag_mismatch("attr_type", 32'(got.attr_type), 32'(want.attr_type));
            if (got.value_offset != want.value_offset)
                flag_mismatch("value_offset", 32'(got.value_offset),
                              32'(want.value_offset));
            if (got.value_length != want.value_length)
                flag_mismatch("value_length", 32'(got.value_length),
                              32'(want.value_length));
            if (got.status != want.status)
                flag_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.cfg_type != want.cfg_type)
                flag_mismatch("cfg_type", 32'(got.cfg_type), 32'(want.cfg_type));
            if (got.attr_count != want.attr_count)
                flag_mismatch("attr_count", 32'(got.attr_count), 32'(want.attr_count));
            if (got.final_mark != want.final_mark)
                flag_mismatch("final_mark", 32'(got.final_mark), 32'(want.final_mark));
        end
    endtask

    // Driver: hold a word until it is taken, predict it on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast);
                words_taken <= words_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (body_words.size() != 0 && (quiet || $urandom_range(99) >= 8))
                begin
                    next_word = body_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.data;
                    s_tlast <= next_word.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each record taken, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                take_record();
            m_tready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 32'd1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_body();
        body_word_t w;
        foreach (body_bytes[i])
        begin
            w.data = body_bytes[i];
            w.last = (i == body_bytes.size() - 1);
            body_words.push_back(w);
        end
        words_queued += body_bytes.size();
        body_bytes.delete();
    endtask

    // Wait until every word is taken and every record seen, then let the
    // output queue settle
    task automatic drain();
        while (words_taken != words_queued || expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [6:0] v);
        attr_limit = v;
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One attribute more than the hard limit, all zero length
    task automatic send_full_body();
        body_bytes = '{8'h01, 8'h00, 8'h00, 8'h00};
        repeat (MAX_ATTRIBUTES_D + 1)
        begin
            body_bytes.push_back(8'($urandom_range(0, 127)));
            body_bytes.push_back(8'($urandom));
            body_bytes.push_back(8'h00);
            body_bytes.push_back(8'h00);
        end
        send_body();
    endtask

    task automatic make_body();
        int          n_attr;
        int          len;
        int          keep;
        int          roll;
        logic [15:0] atype;
        logic [15:0] alen;
        body_bytes.delete();
        roll = int'($urandom_range(99));
        if (roll < 10)
        begin
            // noise
            repeat ($urandom_range(1, 10)) body_bytes.push_back(8'($urandom));
        end
        else
        begin
            body_bytes.push_back(($urandom_range(99) < 6) ? 8'($urandom) :
                                 8'($urandom_range(1, 4)));
            repeat (3)
                body_bytes.push_back(($urandom_range(99) < 4) ? 8'($urandom) : 8'h00);
            n_attr = int'($urandom_range(0, 5));
            repeat (n_attr)
            begin
                atype = 16'($urandom_range(0, 32767));
                if ($urandom_range(99) < 6)
                    atype[15] = 1'b1;
                roll = int'($urandom_range(99));
                if (roll < 65)
                    alen = 16'($urandom_range(0, 6));
                else if (roll < 95)
                    alen = 16'($urandom_range(7, 48));
                else
                    alen = 16'($urandom);
                body_bytes.push_back(atype[15:8]);
                body_bytes.push_back(atype[7:0]);
                body_bytes.push_back(alen[15:8]);
                body_bytes.push_back(alen[7:0]);
                // an overlong length gets only a few value bytes
                len = (alen > 16'd60) ? int'($urandom_range(0, 20)) : int'(alen);
                repeat (len) body_bytes.push_back(8'($urandom));
            end
            roll = int'($urandom_range(99));
            if (roll < 8 && body_bytes.size() > 1)
            begin
                keep = int'($urandom_range(1, body_bytes.size() - 1));
                while (body_bytes.size() > keep)
                    void'(body_bytes.pop_back());
            end
            else if (roll < 13)
                repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom));
        end
        send_body();
    endtask

    initial
    begin
        int p;
        int start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header cut short
        body_bytes = '{8'h01};
        send_body();
        // type below range
        body_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_body();
        // type above range beats nonzero reserved bytes
        body_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_body();
        // reserved byte set, trailing byte dropped
        body_bytes = '{8'h04, 8'h00, 8'h01, 8'h00, 8'h33};
        send_body();
        // empty attribute, then reserved type bit caught after its value
        body_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00,
                       8'h80, 8'h00, 8'h00, 8'h01, 8'hAB};
        send_body();
        drain();

        for (p = 0; p < N_PHASES; p++)
        begin
            set_capacity((p == N_PHASES - 1) ? 7'($urandom) : CAP_PLAN[p]);
            if (attr_limit >= 7'(MAX_ATTRIBUTES_D))
                send_full_body();
            start = words_queued;
            while (words_queued - start < PHASE_BYTES)
                make_body();
            drain();
        end

        if (expected_records.size() != 0)
            flag_mismatch("records never produced", 32'(expected_records.size()), 32'd0);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
